// ----- rtl/core/deq_pkg.sv -----
// Shared command and status codes for the double-ended queue.
package deq_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

endpackage

// ----- rtl/core/deq_store.sv -----
// Word store: one write port, two registered read ports with write bypass.
module deq_store #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]         rd_a_addr,
  input  logic [AW-1:0]         rd_b_addr,
  output logic [DATA_WIDTH-1:0] rd_a_data,
  output logic [DATA_WIDTH-1:0] rd_b_data
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_a_r;
  logic [DATA_WIDTH-1:0] rd_b_r;
  logic [DATA_WIDTH-1:0] wdata_r;
  logic                  byp_a_r;
  logic                  byp_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r  <= mem_r[rd_a_addr];
    rd_b_r  <= mem_r[rd_b_addr];
    // a read that hits the word written in the same cycle takes the new word
    byp_a_r <= wr_en && (wr_addr == rd_a_addr);
    byp_b_r <= wr_en && (wr_addr == rd_b_addr);
    wdata_r <= wr_data;
  end

  assign rd_a_data = byp_a_r ? wdata_r : rd_a_r;
  assign rd_b_data = byp_b_r ? wdata_r : rd_b_r;

endmodule

// ----- rtl/core/double_ended_queue_core.sv -----
// Double-ended queue top level: pointers, count, end-word registers and result register.
// A result is registered and valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless out_stall holds a valid result; the store's two read ports
// prefetch the second word from each end every cycle, so any sequence of operations runs back to back.
// Reset (synchronous, rst_n low) empties the queue and clears the result valid flag;
// the store contents are not cleared and need no clearing pass.
module double_ended_queue_core #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [deq_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [DATA_WIDTH-1:0]  in_push_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_popped_value,
  output logic [deq_pkg::STATUS_W-1:0]  out_status,
  output logic [CW-1:0]                 out_count,
  output logic                          out_is_empty,
  output logic signed [DATA_WIDTH-1:0]  out_front_value,
  output logic signed [DATA_WIDTH-1:0]  out_back_value
);

  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
    inc_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] i);
    dec_idx = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r, back_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [DATA_WIDTH-1:0]       popped;
  deq_pkg::status_t            status;
  logic                        in_fire;
  logic                        full;
  logic                        empty;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] second_front;
  logic [DATA_WIDTH-1:0] second_back;

  logic [DATA_WIDTH-1:0]       popped_r;
  deq_pkg::status_t            status_r;
  logic [CW-1:0]               count_r;
  logic                        is_empty_r;
  logic [DATA_WIDTH-1:0]       front_out_r;
  logic [DATA_WIDTH-1:0]       back_out_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    popped    = '1;
    status    = deq_pkg::ST_DONE;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    if (in_fire) begin
      unique case (in_cmd)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status = deq_pkg::ST_PUSH_FULL;
          end else begin
            head_nxt  = dec_idx(head_r);
            wr_en     = 1'b1;
            wr_addr   = dec_idx(head_r);
            cnt_nxt   = cnt_r + 1'b1;
            front_nxt = in_push_value;
            if (empty) begin
              back_nxt = in_push_value;
            end
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status = deq_pkg::ST_PUSH_FULL;
          end else begin
            tail_nxt = inc_idx(tail_r);
            wr_en    = 1'b1;
            wr_addr  = tail_r;
            cnt_nxt  = cnt_r + 1'b1;
            back_nxt = in_push_value;
            if (empty) begin
              front_nxt = in_push_value;
            end
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status = deq_pkg::ST_POP_EMPTY;
          end else begin
            popped    = front_r;
            head_nxt  = inc_idx(head_r);
            cnt_nxt   = cnt_r - 1'b1;
            front_nxt = second_front;
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status = deq_pkg::ST_POP_EMPTY;
          end else begin
            popped   = back_r;
            tail_nxt = dec_idx(tail_r);
            cnt_nxt  = cnt_r - 1'b1;
            back_nxt = second_back;
          end
        end
        // peek and unused codes leave the queue as it is
        default: begin
        end
      endcase
    end
  end

  // keep the second word from each end of the updated queue in the read registers
  deq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_push_value),
    .rd_a_addr (inc_idx(head_nxt)),
    .rd_b_addr (dec_idx(dec_idx(tail_nxt))),
    .rd_a_data (second_front),
    .rd_b_data (second_back)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    back_r  <= back_nxt;
    if (in_fire) begin
      popped_r    <= popped;
      status_r    <= status;
      count_r     <= cnt_nxt;
      is_empty_r  <= (cnt_nxt == '0);
      front_out_r <= (cnt_nxt == '0) ? '1 : front_nxt;
      back_out_r  <= (cnt_nxt == '0) ? '1 : back_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_count        = count_r;
  assign out_is_empty     = is_empty_r;
  assign out_front_value  = front_out_r;
  assign out_back_value   = back_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("held count exceeds depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_front_value == '1 && out_back_value == '1))
    else $error("end words of empty queue not all ones");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == deq_pkg::ST_PUSH_FULL) |-> (out_count == FULL_CNT))
    else $error("push dropped while queue not full");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full) |=> (head_r == $past(head_r) && tail_r == $past(tail_r)
                           || cnt_r != $past(cnt_r)))
    else $error("pointers moved without count change");

endmodule
